// File: hw/rtl/meter_reply_frame_parser_assert.svh
// Assertion macros for the meter reply frame parser.
// Users must provide signals named clock and reset in scope.
`ifndef METER_REPLY_FRAME_PARSER_ASSERT_SVH
`define METER_REPLY_FRAME_PARSER_ASSERT_SVH

// Property that holds in every cycle outside reset.
`define MRFP_ASSERT_HOLDS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("mrfp: invariant violated");

// Condition in one cycle implies an outcome in the next cycle.
`define MRFP_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("mrfp: sequence check violated");

`endif

// File: hw/rtl/mrfp_pkg.sv
// Package for the meter reply frame parser: frame layout constants,
// status codes and small helper functions. No dependencies.
package mrfp_pkg;

   localparam int BUFFER_BYTES    = 64;
   localparam int PREAMBLE_BYTES  = 4;
   localparam int MAX_VALUE_BYTES = 5;

   localparam int BYTE_W  = 8;
   localparam int POS_W   = $clog2(BUFFER_BYTES);
   localparam int CNT_W   = 3;
   localparam int ADDR_W  = 48;
   localparam int VALUE_W = 34;
   localparam int DP_W    = 8;     // digit pair hi*10+lo, at most 165
   localparam int SCALE_W = 27;    // up to 100^4
   localparam int LO_W    = 21;    // sum of the three lowest pairs
   localparam int T3_W    = 28;    // pair 3 times 100^3
   localparam int CMP_W   = POS_W + 3;

   localparam int ADDR_BYTES   = ADDR_W / BYTE_W;
   localparam int REL_LEN      = 9;
   localparam int REL_SUM_BASE = 10;
   localparam int REL_VALUE    = 14;
   localparam int LEN_MARGIN   = 4;    // identifier bytes ahead of the value
   localparam int TAIL_BYTES   = 12;   // header, checksum and end byte
   localparam int MIN_COUNT    = 3;

   localparam logic [BYTE_W-1:0] START_MARK = 8'h68;
   localparam logic [BYTE_W-1:0] BYTE_BIAS  = 8'h33;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_START = 3'd1,
      ST_BAD_SUM   = 3'd2,
      ST_BAD_VALUE = 3'd3,
      ST_BAD_LEN   = 3'd4
   } status_type;

   // Clamp the configured count into the supported range.
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cfg);
      logic [CNT_W-1:0] c;
      c = cfg;
      if (c < CNT_W'(MIN_COUNT)) begin
         c = CNT_W'(MIN_COUNT);
      end
      if (c > CNT_W'(MAX_VALUE_BYTES)) begin
         c = CNT_W'(MAX_VALUE_BYTES);
      end
      return c;
   endfunction

   // Weight of value byte k: 100^k.
   function automatic logic [SCALE_W-1:0] scale_of(input logic [2:0] k);
      logic [SCALE_W-1:0] s;
      case (k)
         3'd0:    s = SCALE_W'(1);
         3'd1:    s = SCALE_W'(100);
         3'd2:    s = SCALE_W'(10000);
         3'd3:    s = SCALE_W'(1000000);
         default: s = SCALE_W'(100000000);
      endcase
      return s;
   endfunction

   // High nibble times ten plus low nibble.
   function automatic logic [DP_W-1:0] digit_pair(input logic [BYTE_W-1:0] b);
      logic [DP_W-1:0] hi;
      hi = DP_W'(b[7:4]);
      return (hi << 3) + (hi << 1) + DP_W'(b[3:0]);
   endfunction

endpackage

// File: hw/rtl/mrfp_req_if.sv
// Request channel: one received byte per word with its frame-start mark.
// Depends on mrfp_pkg.
interface mrfp_req_if import mrfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_start;

   modport source(output valid, rx_byte, frame_start, input ready);
   modport sink(input valid, rx_byte, frame_start, output ready);
endinterface

// File: hw/rtl/mrfp_rsp_if.sv
// Response channel: one parsed frame result per word.
// Depends on mrfp_pkg.
interface mrfp_rsp_if import mrfp_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [ADDR_W-1:0]  meter_address;
   logic [VALUE_W-1:0] reading_value;

   modport source(output valid, status, meter_address, reading_value, input ready);
   modport sink(input valid, status, meter_address, reading_value, output ready);
endinterface

// File: hw/rtl/meter_reply_frame_parser.sv
// Meter reply frame parser top level: byte-wise frame walker with an input
// register and a result register. Depends on mrfp_pkg, mrfp_req_if,
// mrfp_rsp_if and meter_reply_frame_parser_assert.svh.
//
//   channel   dir   word contents                        handshake
//   req_chan  in    rx_byte[7:0], frame_start            valid/ready
//   rsp_chan  out   status[2:0], meter_address[47:0],    valid/ready
//                   reading_value[33:0]
//   csr_*     in    csr_wr_data[2:0] = value byte count  csr_wr_en, no ready
//
// One byte per cycle while the result channel does not stall. A result word
// is registered after its checksum byte (or bad start/length byte) is
// accepted: the byte is loaded into the input register, then, once no older
// result waits, into the result register. The value is accumulated as bytes
// arrive with one 8x27 multiply per byte, so the checksum cycle only adds three terms.
// Reset is synchronous, clears the pipeline valids and the open-frame flag and
// sets the count register to 4; frame state is cleared by frame_start.
// A stalled result blocks the parse stage; the input register still takes
// one more word while the result waits.
`include "meter_reply_frame_parser_assert.svh"

module meter_reply_frame_parser import mrfp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   mrfp_req_if.sink         req_chan,
   mrfp_rsp_if.source       rsp_chan
);

   // ---------------- configuration ----------------
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(4);
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // ---------------- input register ----------------
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;
   logic              fire;          // parse stage consumes the input register
   logic              rsp_valid_ff;

   assign fire           = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff  <= req_chan.rx_byte;
         in_start_ff <= req_chan.frame_start;
      end
   end

   // ---------------- frame state ----------------
   logic                frame_active_ff, frame_active_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [BYTE_W-1:0]   len_ff, len_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                err_ff, err_in;     // some value byte was below the bias
   logic [LO_W-1:0]     lo_ff, lo_in;       // value bytes 0..2, weighted
   logic [T3_W-1:0]     t3_ff, t3_in;       // value byte 3, weighted
   logic [VALUE_W-1:0]  t4_ff, t4_in;       // value byte 4, weighted

   // start of frame: work from cleared state
   logic                open;
   logic [POS_W-1:0]    off, rel, slot;
   logic [BYTE_W-1:0]   cur_sum, cur_len;
   logic [ADDR_W-1:0]   cur_addr;
   logic                cur_err;
   logic [LO_W-1:0]     cur_lo;
   logic [T3_W-1:0]     cur_t3;
   logic [VALUE_W-1:0]  cur_t4;
   logic [CNT_W-1:0]    cnt;
   logic                is_sum, bad_len;
   logic [BYTE_W-1:0]   unbiased;
   logic [DP_W-1:0]     pair;
   logic [DP_W+SCALE_W-1:0] prod_full;
   logic [VALUE_W-1:0]  prod;
   logic [VALUE_W-1:0]  value_total;

   assign open     = in_start_ff || frame_active_ff;
   assign off      = in_start_ff ? '0 : pos_ff;
   assign rel      = off - POS_W'(PREAMBLE_BYTES);
   assign slot     = rel - POS_W'(REL_VALUE);
   assign cur_sum  = in_start_ff ? '0 : sum_ff;
   assign cur_len  = in_start_ff ? '0 : len_ff;
   assign cur_addr = in_start_ff ? '0 : addr_ff;
   assign cur_err  = in_start_ff ? 1'b0 : err_ff;
   assign cur_lo   = in_start_ff ? '0 : lo_ff;
   assign cur_t3   = in_start_ff ? '0 : t3_ff;
   assign cur_t4   = in_start_ff ? '0 : t4_ff;
   assign cnt      = eff_count(count_ff);

   // checksum byte sits right after the data field
   assign is_sum = (CMP_W'(rel) >= CMP_W'(REL_SUM_BASE)) &&
                   (CMP_W'(rel) == CMP_W'(cur_len) + CMP_W'(REL_SUM_BASE));

   // length must hold the value bytes and leave room in the buffer
   assign bad_len = (CMP_W'(in_byte_ff) < CMP_W'(cnt) + CMP_W'(LEN_MARGIN)) ||
                    (CMP_W'(PREAMBLE_BYTES + TAIL_BYTES) + CMP_W'(in_byte_ff) >
                     CMP_W'(BUFFER_BYTES));

   assign unbiased  = in_byte_ff - BYTE_BIAS;
   assign pair      = digit_pair(unbiased);
   assign prod_full = (DP_W+SCALE_W)'(pair) * (DP_W+SCALE_W)'(scale_of(slot[2:0]));
   assign prod      = prod_full[VALUE_W-1:0];

   assign value_total = VALUE_W'(cur_lo) +
                        ((cnt >= CNT_W'(4)) ? VALUE_W'(cur_t3) : '0) +
                        ((cnt >= CNT_W'(5)) ? cur_t4 : '0);

   // result of this byte
   logic               emit;
   status_type         res_status;
   logic [ADDR_W-1:0]  res_addr;
   logic [VALUE_W-1:0] res_value;

   always_comb begin
      frame_active_in = open;
      pos_in          = pos_ff;
      sum_in          = cur_sum;
      len_in          = cur_len;
      addr_in         = cur_addr;
      err_in          = cur_err;
      lo_in           = cur_lo;
      t3_in           = cur_t3;
      t4_in           = cur_t4;
      emit            = 1'b0;
      res_status      = ST_OK;
      res_addr        = '0;
      res_value       = '0;

      if (open) begin
         pos_in = off + POS_W'(1);
         if (off >= POS_W'(PREAMBLE_BYTES)) begin
            if (rel == '0) begin
               if (in_byte_ff != START_MARK) begin
                  emit       = 1'b1;
                  res_status = ST_BAD_START;
               end else begin
                  sum_in = in_byte_ff;
               end
            end else if (is_sum) begin
               emit     = 1'b1;
               res_addr = cur_addr;
               if (cur_sum != in_byte_ff) begin
                  res_status = ST_BAD_SUM;
               end else if (cur_err) begin
                  res_status = ST_BAD_VALUE;
               end else begin
                  res_status = ST_OK;
                  res_value  = value_total;
               end
            end else begin
               sum_in = cur_sum + in_byte_ff;
               if (rel <= POS_W'(ADDR_BYTES)) begin
                  for (int i = 0; i < ADDR_BYTES; i++) begin
                     if (rel == POS_W'(i + 1)) begin
                        addr_in[BYTE_W*i +: BYTE_W] = cur_addr[BYTE_W*i +: BYTE_W] | in_byte_ff;
                     end
                  end
               end else if (rel == POS_W'(REL_LEN)) begin
                  len_in = in_byte_ff;
                  if (bad_len) begin
                     emit       = 1'b1;
                     res_status = ST_BAD_LEN;
                  end
               end else if (rel >= POS_W'(REL_VALUE)) begin
                  if (slot < POS_W'(cnt)) begin
                     if (in_byte_ff < BYTE_BIAS) begin
                        err_in = 1'b1;
                     end
                     if (slot < POS_W'(MIN_COUNT)) begin
                        lo_in = cur_lo + LO_W'(prod);
                     end else if (slot == POS_W'(MIN_COUNT)) begin
                        t3_in = T3_W'(prod);
                     end else begin
                        t4_in = prod;
                     end
                  end
               end
            end
         end
         if (emit) begin
            frame_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
      end else if (fire) begin
         frame_active_ff <= frame_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         len_ff  <= len_in;
         addr_ff <= addr_in;
         err_ff  <= err_in;
         lo_ff   <= lo_in;
         t3_ff   <= t3_in;
         t4_ff   <= t4_in;
      end
   end

   // ---------------- result register ----------------
   status_type         rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_status_ff <= res_status;
         rsp_addr_ff   <= res_addr;
         rsp_value_ff  <= res_value;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.meter_address = rsp_addr_ff;
   assign rsp_chan.reading_value = rsp_value_ff;

   // ---------------- checks ----------------
   logic rsp_early_fail;   // frame closed on a bad start or length byte
   logic rsp_blank;

   assign rsp_early_fail = (rsp_status_ff == ST_BAD_START) || (rsp_status_ff == ST_BAD_LEN);
   assign rsp_blank      = (rsp_addr_ff == '0) && (rsp_value_ff == '0);

   `MRFP_ASSERT_HOLDS(a_early_fail_blank, !rsp_valid_ff || !rsp_early_fail || rsp_blank)
   `MRFP_ASSERT_HOLDS(a_fail_no_value, !rsp_valid_ff || rsp_status_ff == ST_OK || rsp_value_ff == '0)
   `MRFP_ASSERT_NEXT(a_result_closes_frame, fire && emit, !frame_active_ff)
   `MRFP_ASSERT_NEXT(a_result_registered, fire && emit, rsp_valid_ff)

endmodule

// File: sim/tb_top.sv
// Testbench for meter_reply_frame_parser: random and directed meter reply
// frames, a byte-level parser model and a per-field result check.
// Depends on mrfp_pkg, mrfp_req_if, mrfp_rsp_if and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
   import mrfp_pkg::*;

   // frame offsets relative to the first 0x68
   localparam int OFS_ADDR_LAST = 6;
   localparam int OFS_LEN       = 9;
   localparam int OFS_SUM_BASE  = 10;
   localparam int OFS_VALUE     = 14;
   localparam int ID_BYTES      = 4;
   localparam int FRAME_TAIL    = 12;
   localparam int MAX_LEN       = BUFFER_BYTES - PREAMBLE_BYTES - FRAME_TAIL;

   localparam logic [BYTE_W-1:0] PREAMBLE_FILL = 8'hFE;
   localparam logic [BYTE_W-1:0] END_MARK      = 8'h16;

   localparam int PHASE_WORDS    = 170;
   localparam int SETTLE_CYCLES  = 12;   // two-stage pipe plus margin
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              first;
   } word_type;

   typedef struct {
      status_type         status;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
   } frame_result_type;

   typedef enum int {
      FK_GOOD,
      FK_BAD_SUM,
      FK_LOW_VALUE,
      FK_BAD_START,
      FK_SHORT_LEN,
      FK_LONG_LEN,
      FK_CUT
   } frame_kind_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   mrfp_req_if req_bus();
   mrfp_rsp_if rsp_bus();

   meter_reply_frame_parser dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stimulus and scoreboard storage
   word_type         stim_q[$];
   frame_result_type pending_results[$];

   int fails         = 0;
   int words_queued  = 0;
   int words_in      = 0;
   int results_seen  = 0;
   int settings_used = 1;
   int status_seen[0:7];

   // parser model state, mirrors the frame walker
   logic [POS_W-1:0]  at_pos;
   logic [BYTE_W-1:0] at_sum;
   logic [BYTE_W-1:0] at_len;
   logic [ADDR_W-1:0] at_addr;
   logic [39:0]       at_vals;
   logic              at_low;
   logic              at_open;
   logic [CNT_W-1:0]  count_shadow;

   // count register clamped into 3..MAX_VALUE_BYTES
   function automatic int used_count(input logic [CNT_W-1:0] cfg);
      int c;
      c = int'(cfg);
      if (c < 3) c = 3;
      if (c > MAX_VALUE_BYTES) c = MAX_VALUE_BYTES;
      return c;
   endfunction

   // Walk one accepted byte through the frame model. got is set when the
   // byte closes a frame with a result.
   task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic fs,
                             output logic got, output frame_result_type res);
      int           rel;
      int           n;
      int           k;
      logic [7:0]   v;
      logic [63:0]  acc;
      logic [63:0]  weight;
      got        = 1'b0;
      res.status = ST_OK;
      res.addr   = '0;
      res.value  = '0;
      n          = used_count(count_shadow);
      if (fs) begin
         at_pos  = '0;
         at_sum  = '0;
         at_len  = '0;
         at_addr = '0;
         at_vals = '0;
         at_low  = 1'b0;
         at_open = 1'b1;
      end
      if (!at_open) return;
      rel    = int'(at_pos) - PREAMBLE_BYTES;
      at_pos = at_pos + 1'b1;
      if (rel < 0) return;

      if (rel == 0) begin
         if (b != START_MARK) begin
            got        = 1'b1;
            res.status = ST_BAD_START;
            at_open    = 1'b0;
         end else begin
            at_sum = b;
         end
         return;
      end

      // checksum byte: not part of the sum itself
      if (rel >= OFS_SUM_BASE && rel == OFS_SUM_BASE + int'(at_len)) begin
         got      = 1'b1;
         at_open  = 1'b0;
         res.addr = at_addr;
         if (at_sum != b) begin
            res.status = ST_BAD_SUM;
         end else if (at_low) begin
            res.status = ST_BAD_VALUE;
         end else begin
            acc    = '0;
            weight = 64'd1;
            for (k = 0; k < n; k++) begin
               v      = at_vals[8*k +: 8];
               acc    = acc + (64'(v[7:4]) * 10 + 64'(v[3:0])) * weight;
               weight = weight * 100;
            end
            res.status = ST_OK;
            res.value  = VALUE_W'(acc);
         end
         return;
      end

      at_sum = at_sum + b;
      if (rel <= OFS_ADDR_LAST) begin
         at_addr = at_addr | (ADDR_W'(b) << (8 * (rel - 1)));
      end else if (rel == OFS_LEN) begin
         at_len = b;
         if (int'(b) < n + ID_BYTES ||
             PREAMBLE_BYTES + FRAME_TAIL + int'(b) > BUFFER_BYTES) begin
            got        = 1'b1;
            res.status = ST_BAD_LEN;
            at_open    = 1'b0;
         end
      end else if (rel >= OFS_VALUE && rel - OFS_VALUE < n) begin
         v       = b - BYTE_BIAS;
         at_vals = at_vals | (40'(v) << (8 * (rel - OFS_VALUE)));
         if (b < BYTE_BIAS) at_low = 1'b1;
      end
   endtask

   // Pause length between words: mostly none or short, now and then long,
   // with runs of back-to-back words.
   function automatic int pick_pause(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void put(input logic [BYTE_W-1:0] b, input logic fs,
                               input bit counts);
      word_type w;
      w.data  = b;
      w.first = fs;
      stim_q.push_back(w);
      if (counts) words_queued++;
   endfunction

   // Build one frame of the given kind at the current count setting and
   // queue it. Bytes after a closed frame are ignored and not counted.
   task automatic add_frame(input frame_kind_type kind);
      logic [BYTE_W-1:0] fr[$];
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      int n, len, j, r, low_at, keep, addr_mode, hi, lo;
      n         = used_count(count_shadow);
      addr_mode = $urandom_range(0, 9);
      for (j = 0; j < PREAMBLE_BYTES; j++) begin
         fr.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : PREAMBLE_FILL);
      end

      if (kind == FK_BAD_START) begin
         b = 8'($urandom);
         if (b == START_MARK) b = b + 1'b1;
         fr.push_back(b);
      end else begin
         fr.push_back(START_MARK);
         for (j = 0; j < ADDR_BYTES; j++) begin
            if (addr_mode == 0) fr.push_back(8'h00);
            else if (addr_mode == 1) fr.push_back(8'hFF);
            else fr.push_back(8'($urandom));
         end
         fr.push_back(START_MARK);
         fr.push_back(8'($urandom));     // control byte, never checked

         r = $urandom_range(0, 99);
         case (kind)
            FK_SHORT_LEN: len = (r < 50) ? n + ID_BYTES - 1 : $urandom_range(0, n + 3);
            FK_LONG_LEN:  len = (r < 40) ? MAX_LEN + 1 : $urandom_range(MAX_LEN + 1, 255);
            default: begin
               if (r < 70) len = n + ID_BYTES + $urandom_range(0, 3);
               else if (r < 90) len = $urandom_range(n + ID_BYTES, MAX_LEN);
               else if (r < 95) len = MAX_LEN;
               else len = n + ID_BYTES;
            end
         endcase
         fr.push_back(8'(len));

         if (kind != FK_SHORT_LEN && kind != FK_LONG_LEN) begin
            low_at = $urandom_range(0, n - 1);
            for (j = 0; j < len; j++) begin
               if (j < ID_BYTES || j - ID_BYTES >= n) begin
                  fr.push_back(8'($urandom));
               end else if (kind == FK_LOW_VALUE && j - ID_BYTES == low_at) begin
                  fr.push_back(8'($urandom_range(0, int'(BYTE_BIAS) - 1)));
               end else begin
                  r = $urandom_range(0, 99);
                  if (r < 80) begin
                     hi = (r < 8) ? 9 : $urandom_range(0, 9);
                     lo = (r < 8) ? 9 : $urandom_range(0, 9);
                     fr.push_back(8'((hi << 4) | lo) + BYTE_BIAS);
                  end else if (r < 95) begin
                     // nibbles above 9 still combine as hi*10+lo
                     fr.push_back(8'($urandom_range(int'(BYTE_BIAS), 255)));
                  end else begin
                     fr.push_back(8'($urandom));
                  end
               end
            end
            sum = '0;
            for (j = PREAMBLE_BYTES; j < fr.size(); j++) sum = sum + fr[j];
            if (kind == FK_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
            fr.push_back(sum);
         end
      end

      // a cut frame stops before its checksum; the next frame_start reopens
      if (kind == FK_CUT) begin
         keep = $urandom_range(PREAMBLE_BYTES + 1, fr.size() - 1);
         while (fr.size() > keep) void'(fr.pop_back());
      end

      for (j = 0; j < fr.size(); j++) put(fr[j], j == 0, 1'b1);

      if (kind != FK_CUT) begin
         if (kind != FK_BAD_START && kind != FK_SHORT_LEN && kind != FK_LONG_LEN)
            put(END_MARK, 1'b0, 1'b0);
         if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(1, 6);
            for (j = 0; j < r; j++) put(8'($urandom), 1'b0, 1'b0);
         end
      end
   endtask

   function automatic frame_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return FK_GOOD;
      if (r < 60) return FK_BAD_SUM;
      if (r < 70) return FK_LOW_VALUE;
      if (r < 76) return FK_BAD_START;
      if (r < 82) return FK_SHORT_LEN;
      if (r < 88) return FK_LONG_LEN;
      return FK_CUT;
   endfunction

   // Hold until every queued word went in and every result came back, then
   // let the pipe drain in case the last frame was left open.
   task automatic wait_drained();
      do @(negedge clock);
      while (stim_q.size() != 0 || req_bus.valid || pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= value;
      count_shadow  = value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      settings_used++;
   endtask

   // ---------------------------------------------------------------------
   // Sender: one word per handshake, random pause after each word.
   // ---------------------------------------------------------------------
   int send_wait = 0;
   int send_calm = 0;

   always @(posedge clock) begin
      word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_wait      = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_wait > 0) begin
            send_wait--;
            req_bus.valid <= 1'b0;
         end else if (stim_q.size() != 0) begin
            w = stim_q.pop_front();
            req_bus.rx_byte     <= w.data;
            req_bus.frame_start <= w.first;
            req_bus.valid       <= 1'b1;
            send_wait            = pick_pause(send_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: ready drops for random stretches.
   // ---------------------------------------------------------------------
   int take_wait = 0;
   int take_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_wait      = 0;
      end else if (take_wait > 0) begin
         take_wait--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         take_wait      = pick_pause(take_calm);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: results are checked before the same edge's input word is
   // modeled, so a fresh expectation never pairs with an older result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      frame_result_type want;
      frame_result_type made_res;
      logic             made;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("result word with nothing outstanding: status %0d",
                      rsp_bus.status);
               fails++;
            end else begin
               want = pending_results.pop_front();
               results_seen++;
               status_seen[int'(want.status)]++;
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  fails++;
               end
               if (rsp_bus.meter_address !== want.addr) begin
                  $error("meter_address: expected %h, got %h",
                         want.addr, rsp_bus.meter_address);
                  fails++;
               end
               if (rsp_bus.reading_value !== want.value) begin
                  $error("reading_value: expected %0d, got %0d",
                         want.value, rsp_bus.reading_value);
                  fails++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            words_in++;
            parse_byte(req_bus.rx_byte, req_bus.frame_start, made, made_res);
            if (made) pending_results.push_back(made_res);
         end
      end
   end

   // Watchdog: too long with no word moving on either channel.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no word moved for %0d cycles, %0d results outstanding",
                WATCHDOG_LIMIT, pending_results.size());
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: reset, short directed frames, then random frames under each
   // value byte count. Count changes only with the parser drained.
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] count_plan[7] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd6, 3'd1};

   initial begin
      int p;
      int phase_start;
      int j;

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.rx_byte     = '0;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      count_shadow        = 3'd4;      // register reset value
      at_pos              = '0;
      at_sum              = '0;
      at_len              = '0;
      at_addr             = '0;
      at_vals             = '0;
      at_low              = 1'b0;
      at_open             = 1'b0;
      for (j = 0; j < 8; j++) status_seen[j] = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: stray bytes before any frame, a bad start byte, then a
      // zero length field with an all-ones address
      put(8'h00, 1'b0, 1'b0);
      put(8'hFF, 1'b0, 1'b0);
      for (j = 0; j < PREAMBLE_BYTES; j++) put(8'hFF, j == 0, 1'b1);
      put(8'h00, 1'b0, 1'b1);
      for (j = 0; j < PREAMBLE_BYTES; j++) put(8'h00, j == 0, 1'b1);
      put(START_MARK, 1'b0, 1'b1);
      for (j = 0; j < ADDR_BYTES; j++) put(8'hFF, 1'b0, 1'b1);
      put(START_MARK, 1'b0, 1'b1);
      put(8'h00, 1'b0, 1'b1);
      put(8'h00, 1'b0, 1'b1);

      // random frames at reset count, then at each planned setting
      for (p = 0; p <= 7; p++) begin
         if (p > 0) begin
            wait_drained();
            write_count(count_plan[p-1]);
         end
         phase_start = words_queued;
         while (words_queued - phase_start < PHASE_WORDS) add_frame(pick_kind());
      end

      wait_drained();
      fails += pending_results.size();

      $display("%0d bytes accepted, %0d frame results checked under %0d count settings",
               words_in, results_seen, settings_used);
      $display("by status: ok %0d, start %0d, checksum %0d, low value %0d, length %0d",
               status_seen[ST_OK], status_seen[ST_BAD_START], status_seen[ST_BAD_SUM],
               status_seen[ST_BAD_VALUE], status_seen[ST_BAD_LEN]);
      if (fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
